FILE: sv/crc16re_pkg.sv
// ----------------------------------------------------------------------------
// CRC-16 reflected byte engine package
// Shared widths, reset values, register indexes, queue entry type and the
// byte absorb function of the reflected CRC.
// ----------------------------------------------------------------------------
package crc16re_pkg;

   localparam int CRC_WIDTH   = 16;
   localparam int DATA_WIDTH  = 8;
   localparam int CSR_IDX_WIDTH = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CRC_WIDTH-1:0] POLY_RESET  = 16'hA001;
   localparam logic [CRC_WIDTH-1:0] START_RESET = 16'hFFFF;
   localparam logic [CRC_WIDTH-1:0] CRC_RESET   = 16'hFFFF;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_POLYNOMIAL  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_START_VALUE = 2'd1;

   typedef enum logic {
      OP_CONTINUE,
      OP_RESTART
   } crc16re_op_type;

   typedef struct packed {
      crc16re_op_type        op;
      logic [DATA_WIDTH-1:0] data;
      logic                  last;
   } crc16re_entry_type;

   typedef struct packed {
      logic              valid;
      crc16re_entry_type entry;
   } crc16re_head_type;

   function automatic logic [CRC_WIDTH-1:0] absorb_byte(
      input logic [CRC_WIDTH-1:0]  crc,
      input logic [DATA_WIDTH-1:0] data,
      input logic [CRC_WIDTH-1:0]  poly
   );
      logic [CRC_WIDTH-1:0] value;
      value = crc ^ {{(CRC_WIDTH-DATA_WIDTH){1'b0}}, data};
      for (int k = 0; k < DATA_WIDTH; k++) begin
         if (value[0]) begin
            value = (value >> 1) ^ poly;
         end else begin
            value = value >> 1;
         end
      end
      return value;
   endfunction

endpackage

FILE: sv/crc16re_front.sv
// ----------------------------------------------------------------------------
// CRC-16 front end
// Accepts request beats, tags each byte as a restart or a continuation and
// holds it in a short queue until the back end takes it.
// ----------------------------------------------------------------------------
module crc16re_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [crc16re_pkg::DATA_WIDTH-1:0]   req_data_byte,
   input  logic                                 req_first_byte,
   input  logic                                 req_last_byte,
   output crc16re_pkg::crc16re_head_type        head,
   input  logic                                 pop
);
   import crc16re_pkg::*;

   crc16re_entry_type    queue_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 push;
   logic                 do_pop;
   crc16re_entry_type    new_entry;

   assign req_ready = (count_ff != CNT_WIDTH'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      new_entry.op   = req_first_byte ? OP_RESTART : OP_CONTINUE;
      new_entry.data = req_data_byte;
      new_entry.last = req_last_byte;
   end

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_WIDTH'(push) - CNT_WIDTH'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

endmodule

FILE: sv/crc16re_back.sv
// ----------------------------------------------------------------------------
// CRC-16 back end
// Takes queued bytes, absorbs each into the running CRC register and
// presents the updated value in a registered response stage.
// ----------------------------------------------------------------------------
module crc16re_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  crc16re_pkg::crc16re_head_type        head,
   output logic                                 pop,
   input  logic [crc16re_pkg::CRC_WIDTH-1:0]    polynomial,
   input  logic [crc16re_pkg::CRC_WIDTH-1:0]    start_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [crc16re_pkg::CRC_WIDTH-1:0]    rsp_crc_value,
   output logic                                 rsp_is_final
);
   import crc16re_pkg::*;

   logic [CRC_WIDTH-1:0] crc_ff, crc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CRC_WIDTH-1:0] rsp_crc_ff;
   logic                 rsp_final_ff;
   logic [CRC_WIDTH-1:0] base;
   logic                 out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = head.valid && out_free;

   always_comb begin
      base   = (head.entry.op == OP_RESTART) ? start_value : crc_ff;
      crc_in = absorb_byte(base, head.entry.data, polynomial);
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_crc_ff   <= crc_in;
         rsp_final_ff <= head.entry.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;
   assign rsp_is_final  = rsp_final_ff;

endmodule

FILE: sv/crc16_reflected_byte_engine.sv
// Path: an accepted byte is written into the front-end queue, then the back end absorbs it and registers its CRC beat.
// Throughput: one byte per cycle while the response side is not stalled; the eight-step absorb is combinational.
// A four-entry queue lets the request side keep accepting, until it is full, while a response beat is stalled.
// Reset: synchronous; polynomial 0xA001, start value 0xFFFF, CRC register 0xFFFF, queue empty.
// ----------------------------------------------------------------------------
// CRC-16 reflected byte engine
// Byte-serial reflected CRC-16 with a configurable polynomial and start value.
// ----------------------------------------------------------------------------
module crc16_reflected_byte_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [crc16re_pkg::DATA_WIDTH-1:0]     req_data_byte,
   input  logic                                   req_first_byte,
   input  logic                                   req_last_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [crc16re_pkg::CRC_WIDTH-1:0]      rsp_crc_value,
   output logic                                   rsp_is_final,
   input  logic                                   csr_wr_en,
   input  logic [crc16re_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [crc16re_pkg::CRC_WIDTH-1:0]      csr_wr_data
);
   import crc16re_pkg::*;

   logic [CRC_WIDTH-1:0] poly_ff, poly_in;
   logic [CRC_WIDTH-1:0] start_ff, start_in;
   crc16re_head_type     head;
   logic                 pop;

   always_comb begin
      poly_in  = poly_ff;
      start_in = start_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POLYNOMIAL:  poly_in  = csr_wr_data;
            CSR_START_VALUE: start_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff  <= POLY_RESET;
         start_ff <= START_RESET;
      end else begin
         poly_ff  <= poly_in;
         start_ff <= start_in;
      end
   end

   crc16re_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .head           (head),
      .pop            (pop)
   );

   crc16re_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .polynomial    (poly_ff),
      .start_value   (start_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_crc_value (rsp_crc_value),
      .rsp_is_final  (rsp_is_final)
   );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the reflected CRC-16 byte engine
// Streams directed and random byte messages through the request channel
// under several polynomial and start value settings, predicts the running
// CRC of every beat and checks each response beat in order, with random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module testbench;
   import crc16re_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic [DATA_WIDTH-1:0] data;
      logic                  first;
      logic                  last;
   } byte_item_type;

   typedef struct {
      logic [CRC_WIDTH-1:0] crc;
      logic                 is_final;
   } crc_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [DATA_WIDTH-1:0]    req_data_byte = '0;
   logic                     req_first_byte = 1'b0;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CRC_WIDTH-1:0]     rsp_crc_value;
   logic                     rsp_is_final;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_POLYNOMIAL;
   logic [CRC_WIDTH-1:0]     csr_wr_data = '0;

   byte_item_type        pending_bytes[$];
   crc_beat_type         expected_crc_q[$];
   logic [CRC_WIDTH-1:0] model_poly = POLY_RESET;
   logic [CRC_WIDTH-1:0] model_start = START_RESET;
   logic [CRC_WIDTH-1:0] model_crc = CRC_RESET;
   int                   issued_count = 0;
   int                   answered_count = 0;
   int                   mismatch_count = 0;
   int                   send_gap = 0;
   int                   recv_stall = 0;
   bit                   sender_steady = 1'b0;
   bit                   receiver_steady = 1'b0;

   crc16_reflected_byte_engine dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crc_value  (rsp_crc_value),
      .rsp_is_final   (rsp_is_final),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The byte goes into the low half, then eight shift-right steps each fold in
   // the polynomial when the bit that drops out is set.
   function automatic logic [CRC_WIDTH-1:0] crc_after_byte(
      input logic [CRC_WIDTH-1:0]  crc_in,
      input logic [DATA_WIDTH-1:0] data,
      input logic [CRC_WIDTH-1:0]  poly
   );
      logic [CRC_WIDTH-1:0] acc;
      logic                 dropped;
      acc = {crc_in[CRC_WIDTH-1:DATA_WIDTH], crc_in[DATA_WIDTH-1:0] ^ data};
      repeat (DATA_WIDTH) begin
         dropped = acc[0];
         acc = {1'b0, acc[CRC_WIDTH-1:1]} ^ (poly & {CRC_WIDTH{dropped}});
      end
      return acc;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 24);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_data();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return DATA_WIDTH'($urandom_range(0, 255));
   endfunction

   task automatic queue_byte(input logic [DATA_WIDTH-1:0] data, input logic first,
                             input logic last);
      byte_item_type item;
      item.data = data;
      item.first = first;
      item.last = last;
      pending_bytes.push_back(item);
      issued_count++;
   endtask

   // Mostly well-formed messages; some with random flags, some left open.
   task automatic queue_message(output int count);
      int kind;
      int len;
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
         if (kind == 8) begin
            queue_byte(pick_data(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            queue_byte(pick_data(), k == 0, (kind != 9) && (k == len - 1));
         end
      end
      count = len;
   endtask

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CRC_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      if (idx == CSR_POLYNOMIAL) begin
         model_poly = value;
      end else if (idx == CSR_START_VALUE) begin
         model_start = value;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (answered_count != issued_count) begin
         @(posedge clock);
      end
   endtask

   task automatic randomize_config();
      logic [CRC_WIDTH-1:0] poly;
      logic [CRC_WIDTH-1:0] start;
      int                   which;
      case ($urandom_range(0, 5))
         0: poly = 16'h0000;
         1: poly = 16'hFFFF;
         2: poly = POLY_RESET;
         3: poly = 16'h8408;
         default: poly = CRC_WIDTH'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 3))
         0: start = 16'h0000;
         1: start = 16'hFFFF;
         default: start = CRC_WIDTH'($urandom_range(0, 16'hFFFF));
      endcase
      which = $urandom_range(0, 2);
      if (which != 2) begin
         write_csr(CSR_POLYNOMIAL, poly);
      end
      if (which != 1) begin
         write_csr(CSR_START_VALUE, start);
      end
      if ($urandom_range(0, 3) == 0) begin
         write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                   CRC_WIDTH'($urandom_range(0, 16'hFFFF)));
      end
   endtask

   always @(posedge clock) begin
      byte_item_type item;
      crc_beat_type  beat;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
         model_crc = CRC_RESET;
      end else begin
         if (req_valid && req_ready) begin
            if (req_first_byte) begin
               model_crc = model_start;
            end
            model_crc = crc_after_byte(model_crc, req_data_byte, model_poly);
            beat.crc = model_crc;
            beat.is_final = req_last_byte;
            expected_crc_q.push_back(beat);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_bytes.size() > 0) begin
               item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= item.data;
               req_first_byte <= item.first;
               req_last_byte <= item.last;
               send_gap <= sender_steady ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      crc_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_crc_q.size() == 0) begin
               $error("unexpected result beat: crc_value actual %h", rsp_crc_value);
               mismatch_count++;
            end else begin
               want = expected_crc_q.pop_front();
               answered_count++;
               if (rsp_crc_value !== want.crc) begin
                  $error("crc_value: expected %h, actual %h", want.crc, rsp_crc_value);
                  mismatch_count++;
               end
               if (rsp_is_final !== want.is_final) begin
                  $error("is_final: expected %0b, actual %0b", want.is_final, rsp_is_final);
                  mismatch_count++;
               end
            end
         end
         if (recv_stall > 0) begin
            rsp_ready <= 1'b0;
            recv_stall <= recv_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (!receiver_steady && $urandom_range(0, 3) == 0) begin
               recv_stall <= pick_gap();
            end
         end
      end
   end

   initial begin
      int added;
      int phase_bytes;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings; the first bytes arrive with no first flag.
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_byte(8'h31, 1'b1, 1'b1);
      for (int k = 0; k < 9; k++) begin
         queue_byte(DATA_WIDTH'(8'h31 + k), k == 0, k == 8);
      end
      wait_idle();

      // Polynomial 0x8408 with start value 0x0000; the phase ends in the middle of a message.
      write_csr(CSR_POLYNOMIAL, 16'h8408);
      write_csr(CSR_START_VALUE, 16'h0000);
      queue_byte(8'h00, 1'b1, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b1);
      queue_byte(8'h01, 1'b1, 1'b0);
      wait_idle();

      // The new polynomial applies at once, the new start value only at a first flag.
      write_csr(CSR_POLYNOMIAL, 16'hFFFF);
      write_csr(CSR_START_VALUE, 16'hFFFF);
      queue_byte(8'h7E, 1'b0, 1'b0);
      queue_byte(8'h81, 1'b0, 1'b1);
      queue_byte(8'hC3, 1'b1, 1'b1);
      wait_idle();

      // Writes to unused indexes must leave both registers alone.
      write_csr(CSR_POLYNOMIAL, 16'h0000);
      write_csr(CSR_START_VALUE, 16'h0000);
      write_csr(CSR_SPARE_2, 16'hFFFF);
      write_csr(CSR_SPARE_3, 16'hA5A5);
      queue_byte(8'hFF, 1'b1, 1'b1);
      queue_byte(8'h55, 1'b0, 1'b0);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase != 3) begin
            randomize_config();
         end
         sender_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
         receiver_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
         phase_bytes = 0;
         while (phase_bytes < 160) begin
            queue_message(added);
            phase_bytes += added;
         end
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: sim.f
sv/crc16re_pkg.sv
sv/crc16re_front.sv
sv/crc16re_back.sv
sv/crc16_reflected_byte_engine.sv
tb/testbench.sv
